### src/rkc_pkg.sv
package rkc_pkg;

	// kernel geometry and pixel format
	localparam int KERNEL = 3;
	localparam int TAPS = KERNEL * KERNEL;
	localparam int CHANNELS = 3;
	localparam int PIX_BITS = 8;
	localparam int RGB_BITS = CHANNELS * PIX_BITS;
	localparam int FRAC_BITS = 8;
	localparam int ROW_BITS = 17;
	localparam int HEIGHT_BITS = 16;
	localparam int WIDTH_REG_BITS = 11;
	localparam int COEF_REG_BITS = 48;
	localparam logic [PIX_BITS-1:0] PIX_MAX = 8'd255;
	localparam logic [PIX_BITS-1:0] PIX_MIN = 8'd0;

	// register map, index = paddr / 8
	typedef enum logic [2:0] {
		REG_WIDTH    = 3'd0,
		REG_HEIGHT   = 3'd1,
		REG_COEF_TOP = 3'd2,
		REG_COEF_MID = 3'd3,
		REG_COEF_BOT = 3'd4
	} reg_idx_t;

	// control that travels with the operands of stage 1
	typedef struct packed {
		logic valid;
		logic last;
	} s1_ctl_t;

	// load enables of the lane pipeline stages
	typedef struct packed {
		logic s2;
		logic s3;
	} stage_en_t;

endpackage

### src/rkc_ram.sv
module rkc_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/rkc_window.sv
module rkc_window import rkc_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              restart,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]    width,
	input  logic [HEIGHT_BITS-1:0]            height,
	input  logic                              accept,
	input  logic                              load,
	input  logic                              mode,
	input  logic [PIX_BITS-1:0]               in_red,
	input  logic [PIX_BITS-1:0]               in_green,
	input  logic [PIX_BITS-1:0]               in_blue,
	output s1_ctl_t                           ctl_s1,
	output logic [RGB_BITS-1:0]               opnd_s1 [TAPS]
);

	localparam int WB = $clog2(MAX_WIDTH + 1);
	localparam int XB = $clog2(MAX_WIDTH);

	logic [XB-1:0]         col_q;
	logic [ROW_BITS-1:0]   row_q;
	logic [RGB_BITS-1:0]   wa_q [KERNEL];
	logic [RGB_BITS-1:0]   wb_q [KERNEL];
	logic                  fwd_q;
	logic [2*RGB_BITS-1:0] fwd_data_q;

	logic [2*RGB_BITS-1:0] rd_data;
	logic [2*RGB_BITS-1:0] line_rd;
	logic [2*RGB_BITS-1:0] wr_data;
	logic [RGB_BITS-1:0]   pix;
	logic [RGB_BITS-1:0]   fresh [KERNEL];
	logic [XB-1:0]         col_next;
	logic                  col_wrap;
	logic                  has_out;
	logic                  last;
	logic [ROW_BITS-1:0]   bot_row;
	logic [ROW_BITS:0]     h_ext;
	logic                  row_ok [KERNEL];
	logic                  col_ok [KERNEL];
	logic [RGB_BITS-1:0]   opnd [TAPS];

	// drain items enter as zero pixels
	assign pix = mode ? '0 : {in_blue, in_green, in_red};

	// line store entry = {upper row, lower row}, forwarded when just written
	assign line_rd  = fwd_q ? fwd_data_q : rd_data;
	assign fresh[0] = line_rd[2*RGB_BITS-1:RGB_BITS];
	assign fresh[1] = line_rd[RGB_BITS-1:0];
	assign fresh[2] = pix;
	assign wr_data  = {fresh[1], pix};

	// raster position of the next item
	assign col_wrap = (WB'(col_q) + WB'(1)) >= width;
	assign col_next = (last || col_wrap) ? '0 : col_q + XB'(1);

	// output (i,j) leaves with input (i+1,j+1), or (i+2,0) for the last column
	assign has_out = (row_q >= ROW_BITS'(2)) || (row_q != '0 && col_q != '0);
	assign bot_row = (col_q != '0) ? row_q : row_q - ROW_BITS'(1);
	assign h_ext   = (ROW_BITS+1)'(height);
	assign last    = (col_q == '0) && ((ROW_BITS+1)'(row_q) == h_ext + (ROW_BITS+1)'(1));

	// rows outside the image and columns past the border read as zero
	always_comb begin
		row_ok[2] = (ROW_BITS+1)'(bot_row) < h_ext;
		row_ok[1] = (bot_row != '0) && ((ROW_BITS+1)'(bot_row) <= h_ext);
		row_ok[0] = (bot_row >= ROW_BITS'(2)) &&
			((ROW_BITS+1)'(bot_row) <= h_ext + (ROW_BITS+1)'(1));
		col_ok[0] = !((col_q == XB'(1)) || (col_q == '0 && width == WB'(1)));
		col_ok[1] = 1'b1;
		col_ok[2] = (col_q != '0);
	end

	// operand selection, index = row * 3 + column
	always_comb begin
		for (int k = 0; k < KERNEL; k++) begin
			opnd[k*KERNEL + 0] = (row_ok[k] && col_ok[0]) ? wa_q[k] : '0;
			opnd[k*KERNEL + 1] = (row_ok[k] && col_ok[1]) ? wb_q[k] : '0;
			opnd[k*KERNEL + 2] = (row_ok[k] && col_ok[2]) ? fresh[k] : '0;
		end
	end

	rkc_ram #(
		.WIDTH(2 * RGB_BITS),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk  (clk),
		.we   (accept),
		.waddr(col_q),
		.wdata(wr_data),
		.re   (accept),
		.raddr(col_next),
		.rdata(rd_data)
	);

	// position, window and forwarding control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			fwd_q <= 1'b0;
			for (int k = 0; k < KERNEL; k++) begin
				wa_q[k] <= '0;
				wb_q[k] <= '0;
			end
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
			for (int k = 0; k < KERNEL; k++) begin
				wa_q[k] <= '0;
				wb_q[k] <= '0;
			end
		end else if (accept) begin
			fwd_q <= (col_next == col_q);
			col_q <= col_next;
			if (last) begin
				row_q <= '0;
				for (int k = 0; k < KERNEL; k++) begin
					wa_q[k] <= '0;
					wb_q[k] <= '0;
				end
			end else begin
				if (col_wrap) begin
					row_q <= row_q + ROW_BITS'(1);
				end
				for (int k = 0; k < KERNEL; k++) begin
					wa_q[k] <= wb_q[k];
					wb_q[k] <= fresh[k];
				end
			end
		end
	end

	// copy of the just written entry
	always_ff @(posedge clk) begin
		if (accept) begin
			fwd_data_q <= wr_data;
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (load) begin
			ctl_s1.valid <= accept && has_out;
			ctl_s1.last  <= last;
		end
	end

	// stage 1 operands
	always_ff @(posedge clk) begin
		if (load) begin
			opnd_s1 <= opnd;
		end
	end

endmodule

### src/rkc_lane.sv
module rkc_lane import rkc_pkg::*; #(
	parameter int COEF_BITS = 16
) (
	input  logic                        clk,
	input  stage_en_t                   en,
	input  logic [PIX_BITS-1:0]         pix_s1 [TAPS],
	input  logic signed [COEF_BITS-1:0] coef [TAPS],
	output logic [PIX_BITS-1:0]         result
);

	localparam int PW = COEF_BITS + PIX_BITS + 1;
	localparam int RW = PW + 2;
	localparam int TW = PW + 4;

	logic signed [PW-1:0] prod_s2 [TAPS];
	logic signed [RW-1:0] row_s3 [KERNEL];
	logic signed [TW-1:0] total;

	// one small multiplier per tap
	always_ff @(posedge clk) begin
		if (en.s2) begin
			for (int i = 0; i < TAPS; i++) begin
				prod_s2[i] <= PW'($signed({1'b0, pix_s1[i]})) * PW'(coef[i]);
			end
		end
	end

	// row sums
	always_ff @(posedge clk) begin
		if (en.s3) begin
			for (int k = 0; k < KERNEL; k++) begin
				row_s3[k] <= RW'(prod_s2[k*KERNEL]) + RW'(prod_s2[k*KERNEL + 1]) +
					RW'(prod_s2[k*KERNEL + 2]);
			end
		end
	end

	// final sum, drop fraction, clamp to pixel range
	always_comb begin
		total = TW'(row_s3[0]) + TW'(row_s3[1]) + TW'(row_s3[2]);
		if (total[TW-1]) begin
			result = PIX_MIN;
		end else if (|total[TW-2:FRAC_BITS+PIX_BITS]) begin
			result = PIX_MAX;
		end else begin
			result = total[FRAC_BITS+PIX_BITS-1:FRAC_BITS];
		end
	end

endmodule

### src/rgb_kernel_convolution.sv
// 3x3 convolution of an RGB pixel stream in raster order. Each channel is
// correlated (no kernel flip) with three rows of signed Q8.8 coefficients;
// positions outside the image read as zero, and each sum is truncated toward
// zero and clamped to 0..255. The block takes one request per clock and keeps
// that rate as long as results are taken: the line store is a single
// MAX_WIDTH x 48 RAM (upper and lower rows side by side) whose next column is
// read ahead, and three channel lanes of nine multipliers each work in
// parallel. The result for pixel (i,j) follows the request at (i+1,j+1), or
// (i+2,0) for the last column; after the last pixel of a frame send
// image_width+1 drain requests (mode=1) to flush the tail. frame_last marks
// the final pixel, after which a new frame starts. Writing image_width or
// image_height restarts the frame; coefficient writes take effect at once.
// Registers sit at byte address 8*index; write them only while the block is
// idle, which it does not enforce. No clearing pass is needed after reset.
module rgb_kernel_convolution import rkc_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int COEF_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	// config port
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [5:0]    paddr,
	input  logic [63:0]   pwdata,
	output logic [63:0]   prdata,
	output logic          pready,
	// pixel requests
	input  logic          pix_valid,
	output logic          pix_ready,
	input  logic          mode,
	input  logic [7:0]    in_red,
	input  logic [7:0]    in_green,
	input  logic [7:0]    in_blue,
	// filtered pixels
	output logic          res_valid,
	input  logic          res_ready,
	output logic [7:0]    out_red,
	output logic [7:0]    out_green,
	output logic [7:0]    out_blue,
	output logic          frame_last
);

	localparam int WB = $clog2(MAX_WIDTH + 1);

	logic [WIDTH_REG_BITS-1:0] width_q;
	logic [HEIGHT_BITS-1:0]    height_q;
	logic [COEF_REG_BITS-1:0]  coef_q [KERNEL];

	logic                      cfg_wr;
	logic                      restart;
	logic [WB-1:0]             width_eff;
	logic [HEIGHT_BITS-1:0]    height_eff;

	s1_ctl_t                   ctl_s1;
	logic [RGB_BITS-1:0]       opnd_s1 [TAPS];
	logic                      accept;
	logic                      e2, e3, e4;
	stage_en_t                 lane_en;
	logic                      v2_q, v3_q;
	logic                      last_s2_q, last_s3_q;
	logic                      res_valid_q;
	logic                      frame_last_q;
	logic [PIX_BITS-1:0]       res_q [CHANNELS];

	logic [PIX_BITS-1:0]         lane_pix [CHANNELS][TAPS];
	logic signed [COEF_BITS-1:0] coef [TAPS];
	logic [PIX_BITS-1:0]         lane_res [CHANNELS];

	// register file
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign restart = cfg_wr &&
		(reg_idx_t'(paddr[5:3]) == REG_WIDTH || reg_idx_t'(paddr[5:3]) == REG_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd1024;
			height_q <= 16'd768;
			for (int k = 0; k < KERNEL; k++) begin
				coef_q[k] <= '0;
			end
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[5:3]))
				REG_WIDTH:    width_q   <= pwdata[WIDTH_REG_BITS-1:0];
				REG_HEIGHT:   height_q  <= pwdata[HEIGHT_BITS-1:0];
				REG_COEF_TOP: coef_q[0] <= pwdata[COEF_REG_BITS-1:0];
				REG_COEF_MID: coef_q[1] <= pwdata[COEF_REG_BITS-1:0];
				REG_COEF_BOT: coef_q[2] <= pwdata[COEF_REG_BITS-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_idx_t'(paddr[5:3]))
			REG_WIDTH:    prdata = 64'(width_q);
			REG_HEIGHT:   prdata = 64'(height_q);
			REG_COEF_TOP: prdata = 64'(coef_q[0]);
			REG_COEF_MID: prdata = 64'(coef_q[1]);
			REG_COEF_BOT: prdata = 64'(coef_q[2]);
			default:      prdata = '0;
		endcase
	end

	// effective geometry
	always_comb begin
		if (width_q == '0) begin
			width_eff = WB'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			width_eff = WB'(MAX_WIDTH);
		end else begin
			width_eff = WB'(width_q);
		end
		height_eff = (height_q == '0) ? HEIGHT_BITS'(1) : height_q;
	end

	// coefficient taps, index = row * 3 + column, left column in low bits
	always_comb begin
		for (int k = 0; k < KERNEL; k++) begin
			for (int x = 0; x < KERNEL; x++) begin
				coef[k*KERNEL + x] = coef_q[k][x*COEF_BITS +: COEF_BITS];
			end
		end
	end

	// stage enables, a stage moves when it is empty or the next one moves
	assign e4        = !res_valid_q || res_ready;
	assign e3        = !v3_q || e4;
	assign e2        = !v2_q || e3;
	assign pix_ready = !ctl_s1.valid || e2;
	assign accept    = pix_valid && pix_ready;
	assign lane_en   = '{s2: e2, s3: e3};

	rkc_window #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (restart),
		.width   (width_eff),
		.height  (height_eff),
		.accept  (accept),
		.load    (pix_ready),
		.mode    (mode),
		.in_red  (in_red),
		.in_green(in_green),
		.in_blue (in_blue),
		.ctl_s1  (ctl_s1),
		.opnd_s1 (opnd_s1)
	);

	// one lane per color channel
	always_comb begin
		for (int ch = 0; ch < CHANNELS; ch++) begin
			for (int i = 0; i < TAPS; i++) begin
				lane_pix[ch][i] = opnd_s1[i][ch*PIX_BITS +: PIX_BITS];
			end
		end
	end

	for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
		rkc_lane #(
			.COEF_BITS(COEF_BITS)
		) u_lane (
			.clk   (clk),
			.en    (lane_en),
			.pix_s1(lane_pix[ch]),
			.coef  (coef),
			.result(lane_res[ch])
		);
	end

	// pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q        <= 1'b0;
			v3_q        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (e2) begin
				v2_q <= ctl_s1.valid;
			end
			if (e3) begin
				v3_q <= v2_q;
			end
			if (e4) begin
				res_valid_q <= v3_q;
			end
		end
	end

	// frame end flags, and merge of the lanes into the output register
	always_ff @(posedge clk) begin
		if (e2) begin
			last_s2_q <= ctl_s1.last;
		end
		if (e3) begin
			last_s3_q <= last_s2_q;
		end
		if (e4) begin
			frame_last_q <= last_s3_q;
			for (int ch = 0; ch < CHANNELS; ch++) begin
				res_q[ch] <= lane_res[ch];
			end
		end
	end

	assign res_valid  = res_valid_q;
	assign out_red    = res_q[0];
	assign out_green  = res_q[1];
	assign out_blue   = res_q[2];
	assign frame_last = frame_last_q;

	// input only blocks when every stage holds a result and the output stalls
	a_block_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_ready |-> (res_valid && !res_ready && v2_q && v3_q && ctl_s1.valid))
		else $error("request blocked with room in the pipeline");

	// a result only appears after stage 3 held one
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(v3_q))
		else $error("result without a stage 3 entry");

	// stage 1 only fills from an accepted request
	a_s1_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ctl_s1.valid) |-> $past(pix_valid && pix_ready))
		else $error("stage 1 filled without a request");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb import rkc_pkg::*; ();

	localparam int MAX_W = 1024;
	localparam int HALF_PERIOD = 2;
	localparam int RESET_CYCLES = 11;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_ITEMS = 660;
	localparam int MAX_PRINTS = 40;
	// register index past the end of the map
	localparam logic [2:0] REG_SPARE = 3'd5;

	typedef struct packed {
		logic       mode;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_req_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} filtered_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [5:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;
	logic        pix_valid = 1'b0;
	logic        pix_ready;
	logic        mode = 1'b0;
	logic [7:0]  in_red = '0;
	logic [7:0]  in_green = '0;
	logic [7:0]  in_blue = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic [7:0]  out_red;
	logic [7:0]  out_green;
	logic [7:0]  out_blue;
	logic        frame_last;

	pix_req_t    pending_pixels [$];
	filtered_t   expected_filtered [$];
	pix_req_t    next_req;
	filtered_t   head_pixel;

	int unsigned send_idle_pct = 12;
	int unsigned recv_idle_pct = 78;
	int unsigned pixels_taken = 0;
	int unsigned random_items = 0;
	int unsigned mismatch_count = 0;
	int unsigned hold_at = 32'hFFFF_FFFF;
	int unsigned hold_left = 0;
	logic        hold_done = 1'b0;
	int unsigned quiet_cycles = 0;

	// shadow of the configuration
	logic [10:0] width_cfg = 11'd1024;
	logic [15:0] height_cfg = 16'd768;
	logic [47:0] coef_cfg [3] = '{48'h0, 48'h0, 48'h0};

	// shadow of the line stores, window and raster position
	bit [23:0]   upper_line [MAX_W];
	bit [23:0]   lower_line [MAX_W];
	bit [23:0]   win [9];
	int unsigned col_pos = 0;
	int unsigned row_pos = 0;

	rgb_kernel_convolution #(
		.MAX_WIDTH(MAX_W),
		.COEF_BITS(16)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.pix_valid(pix_valid),
		.pix_ready(pix_ready),
		.mode(mode),
		.in_red(in_red),
		.in_green(in_green),
		.in_blue(in_blue),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.out_red(out_red),
		.out_green(out_green),
		.out_blue(out_blue),
		.frame_last(frame_last)
	);

	always #HALF_PERIOD clk = ~clk;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS)
			$display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
	endtask

	function automatic int unsigned frame_width();
		if (width_cfg == 0) return 1;
		if (width_cfg > MAX_W) return MAX_W;
		return width_cfg;
	endfunction

	function automatic int unsigned frame_height();
		return (height_cfg == 0) ? 1 : height_cfg;
	endfunction

	function automatic void restart_window();
		col_pos = 0;
		row_pos = 0;
		foreach (win[i]) win[i] = '0;
	endfunction

	// expected output for one accepted request, zero or one result
	task automatic convolve_pixel(input logic is_drain, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b);
		int unsigned w, h, c, ci, cj;
		int acc, pv, cv;
		logic [23:0] pix;
		logic [23:0] fresh [3];
		logic [23:0] cols [3][3];
		logic [7:0] chan [3];
		logic at_end;
		filtered_t res;
		w = frame_width();
		h = frame_height();
		c = (col_pos < w) ? col_pos : 0;
		pix = is_drain ? 24'h0 : {b, g, r};
		fresh[0] = upper_line[c];
		fresh[1] = lower_line[c];
		fresh[2] = pix;
		at_end = 1'b0;
		if (row_pos >= 2 || (row_pos >= 1 && c >= 1)) begin
			// centre of the window that this request completes
			if (c >= 1) begin
				ci = row_pos - 1;
				cj = c - 1;
			end else begin
				ci = row_pos - 2;
				cj = w - 1;
			end
			for (int k = 0; k < 3; k++) begin
				cols[0][k] = win[3 + k];
				cols[1][k] = win[6 + k];
				cols[2][k] = (c >= 1) ? fresh[k] : 24'h0;
			end
			for (int ch = 0; ch < 3; ch++) begin
				acc = 0;
				for (int k = 0; k < 3; k++) begin
					// rows above the top or below the bottom read as zero
					if (ci + k == 0 || ci + k - 1 >= h) continue;
					for (int x = 0; x < 3; x++) begin
						if ((x == 0 && cj == 0) || (x == 2 && cj == w - 1)) continue;
						pv = cols[x][k][8*ch +: 8];
						cv = $signed(coef_cfg[k][16*x +: 16]);
						acc += pv * cv;
					end
				end
				// truncate the q8.8 sum and clamp
				if (acc < 0) chan[ch] = PIX_MIN;
				else if ((acc >>> FRAC_BITS) > 255) chan[ch] = PIX_MAX;
				else chan[ch] = 8'(acc >>> FRAC_BITS);
			end
			at_end = (ci == h - 1 && cj == w - 1);
			res.red = chan[0];
			res.green = chan[1];
			res.blue = chan[2];
			res.last = at_end;
			expected_filtered.push_back(res);
		end
		// shift line stores and window
		upper_line[c] = lower_line[c];
		lower_line[c] = pix;
		for (int i = 0; i < 6; i++) win[i] = win[i + 3];
		win[6] = fresh[0];
		win[7] = fresh[1];
		win[8] = fresh[2];
		c++;
		if (c >= w) begin
			c = 0;
			row_pos++;
		end
		col_pos = c;
		if (at_end) restart_window();
	endtask

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
		end else begin
			if (pix_valid && pix_ready === 1'b1) begin
				convolve_pixel(mode, in_red, in_green, in_blue);
				pixels_taken <= pixels_taken + 1;
			end
			if (!pix_valid || pix_ready === 1'b1) begin
				if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_req = pending_pixels.pop_front();
					pix_valid <= 1'b1;
					mode <= next_req.mode;
					in_red <= next_req.red;
					in_green <= next_req.green;
					in_blue <= next_req.blue;
				end else begin
					pix_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, started once
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && pixels_taken >= hold_at) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_valid === 1'b1 && res_ready) begin
				if (expected_filtered.size() == 0) begin
					report_mismatch("result with nothing pending",
						{out_red, out_green, out_blue, frame_last}, 0);
				end else begin
					head_pixel = expected_filtered.pop_front();
					if (out_red !== head_pixel.red)
						report_mismatch("out_red", out_red, head_pixel.red);
					if (out_green !== head_pixel.green)
						report_mismatch("out_green", out_green, head_pixel.green);
					if (out_blue !== head_pixel.blue)
						report_mismatch("out_blue", out_blue, head_pixel.blue);
					if (frame_last !== head_pixel.last)
						report_mismatch("frame_last", frame_last, head_pixel.last);
				end
			end
			res_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// watchdog on cycles with no transfer anywhere
	always @(posedge clk) begin
		if (!arst_n || (pix_valid && pix_ready === 1'b1) ||
				(res_valid === 1'b1 && res_ready) || (psel && penable && pready === 1'b1)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic apb_xfer(input logic wr, input logic [2:0] idx, input logic [63:0] wdata,
			output logic [63:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 3'b000};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// write a register, mirror it and read it back if it is in the map
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		logic [63:0] rd;
		logic [63:0] want;
		want = '0;
		apb_xfer(1'b1, idx, value, rd);
		case (idx)
			REG_WIDTH: begin
				width_cfg = value[10:0];
				restart_window();
				want = 64'(value[10:0]);
			end
			REG_HEIGHT: begin
				height_cfg = value[15:0];
				restart_window();
				want = 64'(value[15:0]);
			end
			REG_COEF_TOP, REG_COEF_MID, REG_COEF_BOT: begin
				coef_cfg[idx - REG_COEF_TOP] = value[47:0];
				want = 64'(value[47:0]);
			end
			default: ;
		endcase
		if (idx <= REG_COEF_BOT) begin
			apb_xfer(1'b0, idx, 64'h0, rd);
			if (rd !== want) report_mismatch($sformatf("readback of register %0d", idx), rd, want);
		end
	endtask

	// all requests taken, all results back, pipeline settled
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_pixels.size() != 0 || pix_valid || expected_filtered.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_pixel(input logic m, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		pix_req_t req;
		req.mode = m;
		req.red = r;
		req.green = g;
		req.blue = b;
		pending_pixels.push_back(req);
	endtask

	function automatic logic [7:0] pick_channel();
		case ($urandom_range(0, 7))
			0: return PIX_MIN;
			1: return PIX_MAX;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [47:0] coef_row();
		logic [15:0] cf [3];
		for (int x = 0; x < 3; x++) begin
			case ($urandom_range(0, 7))
				0: cf[x] = 16'h7FFF;
				1: cf[x] = 16'h8000;
				2: cf[x] = 16'($urandom);
				3: cf[x] = 16'h0000;
				default: cf[x] = 16'($urandom_range(0, 192)) - 16'd64;
			endcase
		end
		return {cf[2], cf[1], cf[0]};
	endfunction

	// raster positions from..upto-1; past in_image mostly drains, some stray pixels
	task automatic queue_frame(input int unsigned from, input int unsigned upto,
			input int unsigned in_image);
		logic m;
		for (int unsigned k = from; k < upto; k++) begin
			if (k < in_image) m = ($urandom_range(0, 15) == 0);
			else m = ($urandom_range(0, 5) != 0);
			push_pixel(m, pick_channel(), pick_channel(), pick_channel());
		end
	endtask

	// one frame of random geometry and kernel, sometimes cut short or rekerneled midway
	task automatic run_random_frame();
		int unsigned w_raw, h_raw, w, h, total, cut, split;
		case ($urandom_range(0, 15))
			0: w_raw = 0;
			1: w_raw = $urandom_range(13, 32);
			default: w_raw = $urandom_range(1, 12);
		endcase
		case ($urandom_range(0, 15))
			0: h_raw = 0;
			1: h_raw = $urandom_range(7, 12);
			default: h_raw = $urandom_range(1, 6);
		endcase
		write_reg(REG_WIDTH, 64'(w_raw));
		write_reg(REG_HEIGHT, 64'(h_raw));
		for (int k = 0; k < 3; k++)
			if ($urandom_range(0, 1)) write_reg(3'(REG_COEF_TOP + k), 64'(coef_row()));
		w = frame_width();
		h = frame_height();
		total = w * h + w + 1;
		cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, total) : total;
		split = ($urandom_range(0, 3) == 0) ? $urandom_range(1, cut) : cut;
		queue_frame(0, split, w * h);
		if (split < cut) begin
			wait_idle();
			write_reg(REG_COEF_MID, 64'(coef_row()));
			queue_frame(split, cut, w * h);
		end
		wait_idle();
		random_items += cut;
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 3x3 frame with extreme coefficients and pixels
		write_reg(REG_WIDTH, 64'd3);
		write_reg(REG_HEIGHT, 64'd3);
		write_reg(REG_COEF_TOP, 64'h0100_8000_7FFF);
		write_reg(REG_COEF_MID, 64'hFF00_0200_0100);
		write_reg(REG_COEF_BOT, 64'hFFFF_0000_0080);
		push_pixel(1'b0, 8'd255, 8'd255, 8'd255);
		push_pixel(1'b0, 8'd0, 8'd0, 8'd0);
		push_pixel(1'b0, 8'd255, 8'd0, 8'd128);
		push_pixel(1'b0, 8'd1, 8'd2, 8'd4);
		// drain inside the image, payload must be ignored
		push_pixel(1'b1, 8'd77, 8'd77, 8'd77);
		wait_idle();
		// spare address and a coefficient change, neither restarts the frame
		write_reg(REG_SPARE, 64'h3);
		write_reg(REG_COEF_BOT, 64'h0040_0100_FFC0);
		push_pixel(1'b0, 8'd128, 8'd64, 8'd32);
		push_pixel(1'b0, 8'd255, 8'd255, 8'd0);
		push_pixel(1'b0, 8'd0, 8'd255, 8'd255);
		push_pixel(1'b0, 8'd170, 8'd85, 8'd15);
		// tail with a stray pixel below the bottom edge
		push_pixel(1'b1, 8'd0, 8'd0, 8'd0);
		push_pixel(1'b1, 8'd0, 8'd0, 8'd0);
		push_pixel(1'b0, 8'd255, 8'd255, 8'd255);
		push_pixel(1'b1, 8'd255, 8'd255, 8'd255);
		wait_idle();

		// zero width and height act as one, identity kernel
		write_reg(REG_WIDTH, 64'd0);
		write_reg(REG_HEIGHT, 64'd0);
		write_reg(REG_COEF_TOP, 64'h0);
		write_reg(REG_COEF_MID, 64'h0000_0100_0000);
		write_reg(REG_COEF_BOT, 64'h0);
		push_pixel(1'b0, 8'd255, 8'd0, 8'd170);
		push_pixel(1'b1, 8'd0, 8'd0, 8'd0);
		push_pixel(1'b0, 8'd9, 8'd9, 8'd9);
		wait_idle();

		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					send_idle_pct = 12;
					recv_idle_pct = 78;
				end
				1: begin
					send_idle_pct = 78;
					recv_idle_pct = 12;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if (p == 1) begin
				// tallest frame, oversized width acts as the maximum, cut short;
				// hold-off lands in row two
				write_reg(REG_WIDTH, 64'h7FF);
				write_reg(REG_HEIGHT, 64'hFFFF);
				write_reg(REG_COEF_TOP, 64'(coef_row()));
				write_reg(REG_COEF_MID, 64'(coef_row()));
				write_reg(REG_COEF_BOT, 64'(coef_row()));
				hold_at = pixels_taken + MAX_W + 60;
				queue_frame(0, MAX_W + 200, MAX_W + 200);
				wait_idle();
			end
			while (random_items < (p + 1) * RANDOM_ITEMS / 3) run_random_frame();
		end

		wait_idle();
		if (mismatch_count == 0 && expected_filtered.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
